// ===== design/spte_pkg.sv =====
// Shared widths, derived sizes and interface types of the scan path time estimator.
package spte_pkg;

  localparam int COORD_BITS   = 31;
  localparam int FRAC_BITS    = 8;
  localparam int SUM_BITS     = 60;
  localparam int COUNT_BITS   = 20;

  localparam int WEIGHT_BITS  = 63;
  localparam int FACTOR_BITS  = 32;
  localparam int MUL_BITS     = 32;
  localparam int PROD_BITS    = 2 * MUL_BITS;

  // dx^2 + dy^2 needs one bit more than a single square
  localparam int SQ_BITS      = 2 * COORD_BITS + 1;
  localparam int ROOT_BITS    = (SQ_BITS + 2 * FRAC_BITS + 1) / 2;
  localparam int RAD_BITS     = 2 * ROOT_BITS;
  localparam int ADD_BITS     = ((SUM_BITS > ROOT_BITS) ? SUM_BITS : ROOT_BITS) + 1;

  localparam int WACC_BITS    = SUM_BITS + FACTOR_BITS + 2;
  localparam int WEIGHT_SHIFT = 16 + FRAC_BITS;

  localparam int IN_DATA_BITS   = ((2 * COORD_BITS + 7) / 8) * 8;
  localparam int IN_USER_BITS   = 2;
  localparam int USER_PATH_START = 0;
  localparam int USER_PATH_END   = 1;
  localparam int OUT_FIELD_BITS = WEIGHT_BITS + 2 * SUM_BITS + 2 * COUNT_BITS;
  localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

  localparam int CFG_ADDR_BITS = 2;
  localparam int CFG_DATA_BITS = 32;

  typedef struct packed {
    logic busy;
    logic done;
  } sqrt_status_t;

endpackage

// ===== design/scan_path_time_estimator.sv =====
// Top level of the scan path time estimator: sequencer, path state, totals and weight.
// Vertices are taken one at a time. Each distance that an item needs (mark segment,
// jump into a new path, closing segment) runs through the digit-serial square root,
// which produces one of its 40 root bits per cycle, so an item needs from 0 to 3 roots.
// The last vertex of a set then forms the four 32x32 partial products of the weight and
// loads the result.
// A new vertex is taken while a finished result still waits in the output register.
module scan_path_time_estimator (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // point_x, point_y, zero pad
  input  logic [spte_pkg::IN_DATA_BITS-1:0]  in_tdata,
  // path_start, path_end
  input  logic [spte_pkg::IN_USER_BITS-1:0]  in_tuser,
  input  logic                               in_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // weight, jump_length, mark_length, jump_count, segment_count, zero pad
  output logic [spte_pkg::OUT_DATA_BITS-1:0] out_tdata,
  input  logic                               cfg_we,
  input  logic [spte_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [spte_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);
  import spte_pkg::*;

  localparam logic [CFG_ADDR_BITS-1:0] CFG_CLOSED_PATHS = 2'd0;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_JUMP_FACTOR  = 2'd1;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_MARK_FACTOR  = 2'd2;

  localparam int OP_SEG   = 0;
  localparam int OP_JUMP  = 1;
  localparam int OP_CLOSE = 2;
  localparam int OPS      = 3;

  localparam logic [SUM_BITS-1:0]   SUM_MAX   = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NEXT,
    ST_MULX,
    ST_MULY,
    ST_ROOT_GO,
    ST_ROOT,
    ST_FINISH,
    ST_WMUL,
    ST_WLAST,
    ST_EMIT
  } state_t;

  state_t                state_r, state_nxt;
  logic [OPS-1:0]        pend_r, pend_nxt;
  logic [OPS-1:0]        did_r, did_nxt;
  logic                  is_start_r, is_start_nxt;
  logic                  ends_r, ends_nxt;
  logic                  send_r, send_nxt;
  logic                  in_path_r, in_path_nxt;
  logic                  long_r, long_nxt;
  logic                  started_r, started_nxt;
  logic                  closed_r, closed_nxt;
  logic [FACTOR_BITS-1:0] jump_factor_r, jump_factor_nxt;
  logic [FACTOR_BITS-1:0] mark_factor_r, mark_factor_nxt;
  logic [SUM_BITS-1:0]   jump_sum_r, jump_sum_nxt;
  logic [SUM_BITS-1:0]   mark_sum_r, mark_sum_nxt;
  logic [COUNT_BITS-1:0] jumps_r, jumps_nxt;
  logic [COUNT_BITS-1:0] segs_r, segs_nxt;
  logic                  out_tvalid_r, out_tvalid_nxt;
  logic                  acc_v_r, acc_v_nxt;
  logic [1:0]            wstep_r, wstep_nxt;

  logic [COORD_BITS-1:0] ix_r, ix_nxt, iy_r, iy_nxt;
  logic [COORD_BITS-1:0] prev_x_r, prev_x_nxt, prev_y_r, prev_y_nxt;
  logic [COORD_BITS-1:0] first_x_r, first_x_nxt, first_y_r, first_y_nxt;
  logic [COORD_BITS-1:0] tail_x_r, tail_x_nxt, tail_y_r, tail_y_nxt;
  logic [MUL_BITS-1:0]   magx_r, magx_nxt, magy_r, magy_nxt;
  logic [SQ_BITS-1:0]    sq_r, sq_nxt;
  logic                  cur_jump_r, cur_jump_nxt;
  logic [WACC_BITS-1:0]  acc_r, acc_nxt;
  logic                  acc_hi_r, acc_hi_nxt;
  logic [OUT_DATA_BITS-1:0] out_data_r, out_data_nxt;

  logic [MUL_BITS-1:0]   mul_a, mul_b;
  logic [PROD_BITS-1:0]  mul_prod;
  logic                  sqrt_go;
  logic [SQ_BITS-1:0]    sq_sum;
  logic [RAD_BITS-1:0]   sqrt_rad;
  logic [ROOT_BITS-1:0]  sqrt_root;
  sqrt_status_t          sqrt_stat;

  logic [OPS-1:0]        sel;
  logic [COORD_BITS-1:0] ax, ay, bx, by;
  logic                  pstart, pend, send, starts;
  logic [WACC_BITS-1:0]  addend;
  logic [WACC_BITS-1:0]  shifted;
  logic [WEIGHT_BITS-1:0] weight;
  logic [COUNT_BITS:0]   segs_sum, jumps_sum;
  logic [MUL_BITS-1:0]   sum_part;
  logic [SUM_BITS-1:0]   sum_sel;

  function automatic logic [SUM_BITS-1:0] sat_add(input logic [SUM_BITS-1:0] s,
                                                  input logic [ROOT_BITS-1:0] d);
    logic [ADD_BITS-1:0] t;
    t = ADD_BITS'(s) + ADD_BITS'(d);
    return (t > ADD_BITS'(SUM_MAX)) ? SUM_MAX : t[SUM_BITS-1:0];
  endfunction

  function automatic logic [COORD_BITS-1:0] mag_diff(input logic [COORD_BITS-1:0] a,
                                                     input logic [COORD_BITS-1:0] b);
    logic [COORD_BITS:0] d;
    d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
    if (d[COORD_BITS]) begin
      d = -d;
    end
    return d[COORD_BITS-1:0];
  endfunction

  spte_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (mul_prod)
  );

  spte_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_go),
    .radicand (sqrt_rad),
    .root     (sqrt_root),
    .status   (sqrt_stat)
  );

  assign pstart = in_tuser[USER_PATH_START];
  assign pend   = in_tuser[USER_PATH_END];
  assign send   = in_tlast;
  assign starts = pstart || !in_path_r;

  // lowest pending distance goes first
  assign sel[OP_SEG]   = pend_r[OP_SEG];
  assign sel[OP_JUMP]  = pend_r[OP_JUMP] && !pend_r[OP_SEG];
  assign sel[OP_CLOSE] = pend_r[OP_CLOSE] && !pend_r[OP_JUMP] && !pend_r[OP_SEG];

  always_comb begin
    if (sel[OP_SEG]) begin
      ax = ix_r;      ay = iy_r;      bx = prev_x_r;  by = prev_y_r;
    end else if (sel[OP_JUMP]) begin
      ax = tail_x_r;  ay = tail_y_r;  bx = first_x_r; by = first_y_r;
    end else begin
      ax = first_x_r; ay = first_y_r; bx = ix_r;      by = iy_r;
    end
  end

  assign sq_sum   = sq_r + SQ_BITS'(mul_prod);
  assign sqrt_rad = RAD_BITS'(sq_sum) << (2 * FRAC_BITS);

  assign sum_sel  = wstep_r[1] ? mark_sum_r : jump_sum_r;
  assign sum_part = wstep_r[0] ? MUL_BITS'(sum_sel[SUM_BITS-1:MUL_BITS])
                               : sum_sel[MUL_BITS-1:0];

  always_comb begin
    case (state_r)
      ST_MULX: begin
        mul_a = magx_r;
        mul_b = magx_r;
      end
      ST_MULY: begin
        mul_a = magy_r;
        mul_b = magy_r;
      end
      ST_WMUL: begin
        mul_a = wstep_r[1] ? mark_factor_r : jump_factor_r;
        mul_b = sum_part;
      end
      default: begin
        mul_a = magx_r;
        mul_b = magx_r;
      end
    endcase
  end

  assign addend  = acc_hi_r ? (WACC_BITS'(mul_prod) << MUL_BITS) : WACC_BITS'(mul_prod);
  assign shifted = acc_r >> WEIGHT_SHIFT;
  assign weight  = (|shifted[WACC_BITS-1:WEIGHT_BITS]) ? '1 : shifted[WEIGHT_BITS-1:0];

  assign segs_sum  = (COUNT_BITS+1)'(segs_r) + (COUNT_BITS+1)'(did_r[OP_SEG])
                   + (COUNT_BITS+1)'(did_r[OP_CLOSE]);
  assign jumps_sum = (COUNT_BITS+1)'(jumps_r) + (COUNT_BITS+1)'(did_r[OP_JUMP]);

  always_comb begin
    state_nxt       = state_r;
    pend_nxt        = pend_r;
    did_nxt         = did_r;
    is_start_nxt    = is_start_r;
    ends_nxt        = ends_r;
    send_nxt        = send_r;
    in_path_nxt     = in_path_r;
    long_nxt        = long_r;
    started_nxt     = started_r;
    closed_nxt      = closed_r;
    jump_factor_nxt = jump_factor_r;
    mark_factor_nxt = mark_factor_r;
    jump_sum_nxt    = jump_sum_r;
    mark_sum_nxt    = mark_sum_r;
    jumps_nxt       = jumps_r;
    segs_nxt        = segs_r;
    out_tvalid_nxt  = out_tvalid_r;
    acc_v_nxt       = 1'b0;
    wstep_nxt       = wstep_r;
    ix_nxt          = ix_r;
    iy_nxt          = iy_r;
    prev_x_nxt      = prev_x_r;
    prev_y_nxt      = prev_y_r;
    first_x_nxt     = first_x_r;
    first_y_nxt     = first_y_r;
    tail_x_nxt      = tail_x_r;
    tail_y_nxt      = tail_y_r;
    magx_nxt        = magx_r;
    magy_nxt        = magy_r;
    sq_nxt          = sq_r;
    cur_jump_nxt    = cur_jump_r;
    acc_nxt         = acc_r;
    acc_hi_nxt      = acc_hi_r;
    out_data_nxt    = out_data_r;
    sqrt_go         = 1'b0;

    if (acc_v_r) begin
      acc_nxt = acc_r + addend;
    end
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    if (cfg_we) begin
      unique case (cfg_addr)
        CFG_CLOSED_PATHS: closed_nxt      = cfg_wdata[0];
        CFG_JUMP_FACTOR:  jump_factor_nxt = cfg_wdata[FACTOR_BITS-1:0];
        CFG_MARK_FACTOR:  mark_factor_nxt = cfg_wdata[FACTOR_BITS-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          ix_nxt       = in_tdata[COORD_BITS-1:0];
          iy_nxt       = in_tdata[2*COORD_BITS-1:COORD_BITS];
          is_start_nxt = starts;
          ends_nxt     = pend || send;
          send_nxt     = send;
          did_nxt[OP_SEG]   = !starts;
          did_nxt[OP_JUMP]  = !starts && !long_r && started_r;
          did_nxt[OP_CLOSE] = !starts && (pend || send) && closed_r;
          pend_nxt     = did_nxt;
          state_nxt    = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (pend_r != '0) begin
          magx_nxt     = MUL_BITS'(mag_diff(ax, bx));
          magy_nxt     = MUL_BITS'(mag_diff(ay, by));
          cur_jump_nxt = sel[OP_JUMP];
          pend_nxt     = pend_r & ~sel;
          state_nxt    = ST_MULX;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_MULX: begin
        state_nxt = ST_MULY;
      end
      ST_MULY: begin
        sq_nxt    = SQ_BITS'(mul_prod);
        state_nxt = ST_ROOT_GO;
      end
      ST_ROOT_GO: begin
        sqrt_go   = 1'b1;
        state_nxt = ST_ROOT;
      end
      ST_ROOT: begin
        if (sqrt_stat.done) begin
          if (cur_jump_r) begin
            jump_sum_nxt = sat_add(jump_sum_r, sqrt_root);
          end else begin
            mark_sum_nxt = sat_add(mark_sum_r, sqrt_root);
          end
          state_nxt = ST_NEXT;
        end
      end
      ST_FINISH: begin
        if (is_start_r) begin
          in_path_nxt = 1'b1;
          long_nxt    = 1'b0;
          first_x_nxt = ix_r;
          first_y_nxt = iy_r;
          prev_x_nxt  = ix_r;
          prev_y_nxt  = iy_r;
        end else begin
          long_nxt    = 1'b1;
          started_nxt = 1'b1;
          prev_x_nxt  = ix_r;
          prev_y_nxt  = iy_r;
          tail_x_nxt  = ix_r;
          tail_y_nxt  = iy_r;
        end
        if (ends_r) begin
          in_path_nxt = 1'b0;
          long_nxt    = 1'b0;
        end
        segs_nxt  = segs_sum[COUNT_BITS] ? COUNT_MAX : segs_sum[COUNT_BITS-1:0];
        jumps_nxt = jumps_sum[COUNT_BITS] ? COUNT_MAX : jumps_sum[COUNT_BITS-1:0];
        if (send_r) begin
          acc_nxt   = '0;
          wstep_nxt = '0;
          state_nxt = ST_WMUL;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_WMUL: begin
        acc_v_nxt  = 1'b1;
        acc_hi_nxt = wstep_r[0];
        wstep_nxt  = wstep_r + 2'd1;
        if (&wstep_r) begin
          state_nxt = ST_WLAST;
        end
      end
      ST_WLAST: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        // hold until the output register is free, then load and clear the totals
        if (!out_tvalid_r || out_tready) begin
          out_data_nxt   = OUT_DATA_BITS'({segs_r, jumps_r, mark_sum_r, jump_sum_r, weight});
          out_tvalid_nxt = 1'b1;
          jump_sum_nxt   = '0;
          mark_sum_nxt   = '0;
          jumps_nxt      = '0;
          segs_nxt       = '0;
          started_nxt    = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    ix_r       <= ix_nxt;
    iy_r       <= iy_nxt;
    prev_x_r   <= prev_x_nxt;
    prev_y_r   <= prev_y_nxt;
    first_x_r  <= first_x_nxt;
    first_y_r  <= first_y_nxt;
    tail_x_r   <= tail_x_nxt;
    tail_y_r   <= tail_y_nxt;
    magx_r     <= magx_nxt;
    magy_r     <= magy_nxt;
    sq_r       <= sq_nxt;
    cur_jump_r <= cur_jump_nxt;
    acc_r      <= acc_nxt;
    acc_hi_r   <= acc_hi_nxt;
    out_data_r <= out_data_nxt;
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      pend_r        <= '0;
      did_r         <= '0;
      is_start_r    <= 1'b0;
      ends_r        <= 1'b0;
      send_r        <= 1'b0;
      in_path_r     <= 1'b0;
      long_r        <= 1'b0;
      started_r     <= 1'b0;
      closed_r      <= 1'b1;
      jump_factor_r <= '0;
      mark_factor_r <= '0;
      jump_sum_r    <= '0;
      mark_sum_r    <= '0;
      jumps_r       <= '0;
      segs_r        <= '0;
      out_tvalid_r  <= 1'b0;
      acc_v_r       <= 1'b0;
      wstep_r       <= '0;
    end else begin
      state_r       <= state_nxt;
      pend_r        <= pend_nxt;
      did_r         <= did_nxt;
      is_start_r    <= is_start_nxt;
      ends_r        <= ends_nxt;
      send_r        <= send_nxt;
      in_path_r     <= in_path_nxt;
      long_r        <= long_nxt;
      started_r     <= started_nxt;
      closed_r      <= closed_nxt;
      jump_factor_r <= jump_factor_nxt;
      mark_factor_r <= mark_factor_nxt;
      jump_sum_r    <= jump_sum_nxt;
      mark_sum_r    <= mark_sum_nxt;
      jumps_r       <= jumps_nxt;
      segs_r        <= segs_nxt;
      out_tvalid_r  <= out_tvalid_nxt;
      acc_v_r       <= acc_v_nxt;
      wstep_r       <= wstep_nxt;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

  a_root_in_root_state: assert property (@(posedge clk) disable iff (!rst_n)
    (sqrt_stat.busy || sqrt_stat.done) |-> state_r == ST_ROOT)
    else $error("square root active outside its sequencer state");

  a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r) == ST_EMIT)
    else $error("result loaded outside the emit step");

  a_jump_needs_start: assert property (@(posedge clk) disable iff (!rst_n)
    (jump_sum_r != '0) |-> started_r)
    else $error("jump length accumulated without an earlier path");

endmodule

// ===== design/spte_mul.sv =====
// Registered unsigned multiplier shared by the squares and the weight products.
module spte_mul (
  input  logic                           clk,
  input  logic [spte_pkg::MUL_BITS-1:0]  a,
  input  logic [spte_pkg::MUL_BITS-1:0]  b,
  output logic [spte_pkg::PROD_BITS-1:0] prod
);
  import spte_pkg::*;

  logic [PROD_BITS-1:0] prod_r;
  logic [PROD_BITS-1:0] prod_nxt;

  assign prod_nxt = PROD_BITS'(a) * PROD_BITS'(b);

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  assign prod = prod_r;

endmodule

// ===== design/spte_sqrt.sv =====
// Digit-serial integer square root: two radicand bits in and one root bit out per cycle.
module spte_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [spte_pkg::RAD_BITS-1:0] radicand,
  output logic [spte_pkg::ROOT_BITS-1:0] root,
  output spte_pkg::sqrt_status_t        status
);
  import spte_pkg::*;

  localparam int CNT_BITS = $clog2(ROOT_BITS + 1);

  logic [RAD_BITS-1:0]  rad_r, rad_nxt;
  logic [ROOT_BITS:0]   rem_r, rem_nxt;
  logic [ROOT_BITS-1:0] q_r, q_nxt;
  logic [CNT_BITS-1:0]  cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [ROOT_BITS+2:0] rem_sh;
  logic [ROOT_BITS+2:0] trial;
  logic [ROOT_BITS+2:0] diff;
  logic                 fits;

  always_comb begin
    rem_sh   = {rem_r, rad_r[RAD_BITS-1 -: 2]};
    trial    = {1'b0, q_r, 2'b01};
    diff     = rem_sh - trial;
    fits     = (rem_sh >= trial);
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rad_nxt  = radicand;
      rem_nxt  = '0;
      q_nxt    = '0;
      cnt_nxt  = CNT_BITS'(ROOT_BITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // shift the next digit pair in and keep the partial remainder below 2q+1
      rad_nxt = rad_r << 2;
      rem_nxt = fits ? diff[ROOT_BITS:0] : rem_sh[ROOT_BITS:0];
      q_nxt   = {q_r[ROOT_BITS-2:0], fits};
      cnt_nxt = cnt_r - CNT_BITS'(1);
      if (cnt_r == CNT_BITS'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rad_r <= rad_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  assign root        = q_r;
  assign status.busy = busy_r;
  assign status.done = done_r;

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the scan path time estimator: vertex sets in, path totals out.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import spte_pkg::*;

  localparam int          PHASES      = 6;
  localparam int          PHASE_ITEMS = 175;
  localparam int          HOLD_CYCLES = 3000;
  localparam int          SETTLE      = 200;
  localparam int          LIMIT       = 1200000;
  localparam logic [63:0] SUM_MAX     = (64'd1 << SUM_BITS) - 64'd1;
  localparam logic [31:0] COUNT_MAX   = 32'((64'd1 << COUNT_BITS) - 64'd1);
  localparam logic [WEIGHT_BITS-1:0] WEIGHT_MAX = {WEIGHT_BITS{1'b1}};

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    REG_CLOSED_PATHS = 2'd0,
    REG_JUMP_FACTOR  = 2'd1,
    REG_MARK_FACTOR  = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic                  set_end;
    logic                  path_end;
    logic                  path_start;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] x;
  } vertex_t;

  // Packed from the top down, so weight lands in the lowest bits.
  typedef struct packed {
    logic [COUNT_BITS-1:0]  segment_count;
    logic [COUNT_BITS-1:0]  jump_count;
    logic [SUM_BITS-1:0]    mark_length;
    logic [SUM_BITS-1:0]    jump_length;
    logic [WEIGHT_BITS-1:0] weight;
  } totals_t;

  class time_estimate_model;
    logic        closed_mode;
    logic [31:0] jump_q;
    logic [31:0] mark_q;
    logic        started;
    logic        in_path;
    int          path_len;
    longint      end_x, end_y, prev_x, prev_y, first_x, first_y;
    logic [63:0] jump_sum, mark_sum;
    logic [31:0] jumps, segs;
    totals_t     pending[$];
    int          mismatches;

    function new();
      closed_mode = 1'b1;
      jump_q = '0;
      mark_q = '0;
      started = 1'b0;
      in_path = 1'b0;
      path_len = 0;
      end_x = 0; end_y = 0; prev_x = 0; prev_y = 0; first_x = 0; first_y = 0;
      jump_sum = '0;
      mark_sum = '0;
      jumps = '0;
      segs = '0;
      mismatches = 0;
    endfunction

    function void set_reg(reg_index_t idx, logic [31:0] value);
      case (idx)
        REG_CLOSED_PATHS: closed_mode = value[0];
        REG_JUMP_FACTOR:  jump_q = value;
        REG_MARK_FACTOR:  mark_q = value;
        default: ;
      endcase
    endfunction

    function longint widen(logic [COORD_BITS-1:0] c);
      return longint'({{(64-COORD_BITS){c[COORD_BITS-1]}}, c});
    endfunction

    // Exact floor of sqrt((dx^2 + dy^2) << 2*FRAC_BITS), one root bit per step.
    function logic [47:0] seg_length(longint ax, longint ay, longint bx, longint by);
      logic [63:0]  mx, my;
      logic [127:0] rad, trial;
      logic [47:0]  root;
      mx = (ax < bx) ? 64'(bx - ax) : 64'(ax - bx);
      my = (ay < by) ? 64'(by - ay) : 64'(ay - by);
      rad = 128'(mx * mx + my * my) << (2 * FRAC_BITS);
      root = '0;
      for (int b = 47; b >= 0; b--) begin
        trial = 128'(root | (48'd1 << b));
        if (trial * trial <= rad) root = trial[47:0];
      end
      return root;
    endfunction

    function logic [63:0] sat_sum(logic [63:0] s, logic [47:0] d);
      logic [63:0] t;
      t = s + 64'(d);
      return (t > SUM_MAX) ? SUM_MAX : t;
    endfunction

    function logic [31:0] bump(logic [31:0] c);
      return (c >= COUNT_MAX) ? COUNT_MAX : c + 32'd1;
    endfunction

    function logic [WEIGHT_BITS-1:0] weight_of();
      logic [127:0] acc;
      acc = 128'(jump_q) * 128'(jump_sum) + 128'(mark_q) * 128'(mark_sum);
      acc = acc >> (16 + FRAC_BITS);
      if (acc > 128'(WEIGHT_MAX)) return WEIGHT_MAX;
      return acc[WEIGHT_BITS-1:0];
    endfunction

    function void take_vertex(vertex_t v);
      longint  px, py;
      totals_t t;
      px = widen(v.x);
      py = widen(v.y);
      if (v.path_start || !in_path) begin
        in_path = 1'b1;
        path_len = 1;
        first_x = px; prev_x = px;
        first_y = py; prev_y = py;
      end else begin
        mark_sum = sat_sum(mark_sum, seg_length(px, py, prev_x, prev_y));
        segs = bump(segs);
        if (path_len < 2) begin
          path_len = 2;
          // the jump counts only once the new path has a real segment
          if (started) begin
            jump_sum = sat_sum(jump_sum, seg_length(end_x, end_y, first_x, first_y));
            jumps = bump(jumps);
          end
          started = 1'b1;
        end
        prev_x = px; prev_y = py;
        end_x = px; end_y = py;
      end
      if (v.path_end || v.set_end) begin
        if (closed_mode && path_len >= 2) begin
          mark_sum = sat_sum(mark_sum, seg_length(first_x, first_y, prev_x, prev_y));
          segs = bump(segs);
        end
        in_path = 1'b0;
        path_len = 0;
      end
      if (v.set_end) begin
        t.weight = weight_of();
        t.jump_length = jump_sum[SUM_BITS-1:0];
        t.mark_length = mark_sum[SUM_BITS-1:0];
        t.jump_count = jumps[COUNT_BITS-1:0];
        t.segment_count = segs[COUNT_BITS-1:0];
        pending = {pending, t};
        jump_sum = '0;
        mark_sum = '0;
        jumps = '0;
        segs = '0;
        started = 1'b0;
      end
    endfunction

    function void compare_totals(totals_t got);
      totals_t want;
      logic    bad;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with nothing pending: weight %h jump %h mark %h jc %h sc %h",
                   $realtime, got.weight, got.jump_length, got.mark_length,
                   got.jump_count, got.segment_count);
        return;
      end
      want = pending.pop_front();
      bad = (got.weight !== want.weight) || (got.jump_length !== want.jump_length) ||
            (got.mark_length !== want.mark_length) ||
            (got.jump_count !== want.jump_count) ||
            (got.segment_count !== want.segment_count);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: totals mismatch", $realtime);
          $display("  weight        exp %h got %h", want.weight, got.weight);
          $display("  jump_length   exp %h got %h", want.jump_length, got.jump_length);
          $display("  mark_length   exp %h got %h", want.mark_length, got.mark_length);
          $display("  jump_count    exp %h got %h", want.jump_count, got.jump_count);
          $display("  segment_count exp %h got %h", want.segment_count, got.segment_count);
        end
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_tvalid = 1'b0;
  logic                     in_tready;
  logic [IN_DATA_BITS-1:0]  in_tdata = '0;
  logic [IN_USER_BITS-1:0]  in_tuser = '0;
  logic                     in_tlast = 1'b0;
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] out_tdata;
  logic                     cfg_we = 1'b0;
  logic [CFG_ADDR_BITS-1:0] cfg_addr = '0;
  logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

  time_estimate_model model = new();
  int  items_sent = 0;
  int  in_calm = 0;
  int  out_calm = 0;
  int  cycle_count = 0;
  bit  hold_req = 1'b0;

  scan_path_time_estimator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic int pick_gap(inout int calm);
    int r;
    r = $urandom_range(99);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if (r < 3) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [COORD_BITS-1:0] pick_coord(int scale);
    case (scale)
      0: return COORD_BITS'($urandom);
      1: begin
        case ($urandom_range(3))
          0: return {1'b1, {(COORD_BITS-1){1'b0}}};
          1: return {1'b0, {(COORD_BITS-1){1'b1}}};
          2: return '0;
          default: return '1;
        endcase
      end
      default: return COORD_BITS'(int'($urandom_range(4000)) - 2000);
    endcase
  endfunction

  function automatic int pick_scale();
    int r;
    r = $urandom_range(99);
    if (r < 20) return 0;
    if (r < 30) return 1;
    return 2;
  endfunction

  task automatic send_vertex(vertex_t v);
    int                      gap;
    logic [IN_USER_BITS-1:0] u;
    gap = pick_gap(in_calm);
    u = '0;
    u[USER_PATH_START] = v.path_start;
    u[USER_PATH_END] = v.path_end;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= IN_DATA_BITS'({v.y, v.x});
    in_tuser <= u;
    in_tlast <= v.set_end;
    do @(posedge clk); while (!in_tready);
    model.take_vertex(v);
    items_sent++;
  endtask

  task automatic send_point(int x, int y, bit ps, bit pe, bit se);
    vertex_t v;
    v.x = COORD_BITS'(x);
    v.y = COORD_BITS'(y);
    v.path_start = ps;
    v.path_end = pe;
    v.set_end = se;
    send_vertex(v);
  endtask

  task automatic send_directed();
    send_point(5, 7, 0, 0, 0);           // no start flag: opens a path anyway
    send_point(8, 11, 0, 0, 0);
    send_point(0, 0, 0, 1, 0);
    send_point(100, -100, 1, 1, 0);      // lone vertex, no segment, no jump
    send_point(-1073741824, -1073741824, 1, 0, 0);
    send_point(1073741823, 1073741823, 0, 0, 0);
    send_point(-1073741824, 1073741823, 0, 1, 0);
    send_point(3, 3, 0, 0, 0);
    send_point(4, 4, 0, 0, 0);
    send_point(9, 9, 1, 0, 0);           // restart inside an open path
    send_point(10, -3, 0, 0, 1);         // set closes without a path end
    send_point(0, 0, 1, 1, 1);
    send_point(1073741823, -1073741824, 1, 0, 0);
    send_point(-1073741824, 1073741823, 0, 1, 1);
    send_point(0, 0, 0, 0, 1);
  endtask

  task automatic send_random_set();
    int      n_paths, len, scale;
    vertex_t v;
    n_paths = $urandom_range(1, 4);
    for (int p = 0; p < n_paths; p++) begin
      len = ($urandom_range(99) < 15) ? 1 : $urandom_range(2, 6);
      scale = pick_scale();
      for (int k = 0; k < len; k++) begin
        v.x = pick_coord(scale);
        v.y = pick_coord(scale);
        v.path_start = (k == 0) && ($urandom_range(99) < 92);
        v.path_end = (k == len - 1) && ($urandom_range(99) < 88);
        v.set_end = (p == n_paths - 1) && (k == len - 1);
        send_vertex(v);
      end
    end
  endtask

  task automatic send_noise_set();
    int      n;
    vertex_t v;
    n = $urandom_range(1, 6);
    for (int k = 0; k < n; k++) begin
      v.x = pick_coord(pick_scale());
      v.y = pick_coord(pick_scale());
      v.path_start = $urandom_range(1);
      v.path_end = $urandom_range(1);
      // always close the burst with a set end so the phase drains cleanly
      v.set_end = (k == n - 1) ? 1'b1 : ($urandom_range(99) < 15);
      send_vertex(v);
    end
  endtask

  task automatic write_settings(logic cp, logic [31:0] jf, logic [31:0] mf);
    cfg_we <= 1'b1;
    cfg_addr <= REG_CLOSED_PATHS;
    cfg_wdata <= CFG_DATA_BITS'(cp);
    @(posedge clk);
    model.set_reg(REG_CLOSED_PATHS, 32'(cp));
    cfg_addr <= REG_JUMP_FACTOR;
    cfg_wdata <= jf;
    @(posedge clk);
    model.set_reg(REG_JUMP_FACTOR, jf);
    cfg_addr <= REG_MARK_FACTOR;
    cfg_wdata <= mf;
    @(posedge clk);
    model.set_reg(REG_MARK_FACTOR, mf);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_phase(int p);
    logic        cp;
    logic [31:0] jf, mf;
    case (p)
      1: begin cp = 1'b1; jf = 32'h0001_0000; mf = 32'h0001_0000; end
      2: begin cp = 1'b0; jf = 32'hFFFF_FFFF; mf = 32'hFFFF_FFFF; end
      3: begin cp = 1'b1; jf = $urandom; mf = $urandom; end
      4: begin cp = 1'b0; jf = 32'h0000_0000; mf = $urandom; end
      default: begin cp = 1'b1; jf = 32'hFFFF_FFFF; mf = 32'h0000_0001; end
    endcase
    write_settings(cp, jf, mf);
  endtask

  task automatic drain();
    while (model.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    int target;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int p = 0; p < PHASES; p++) begin
      // phase 0 runs on the reset values of the registers
      if (p > 0) apply_phase(p);
      if (p == 0) send_directed();
      if (p == 2) hold_req = 1'b1;
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        if ($urandom_range(99) < 15) send_noise_set();
        else send_random_set();
      end
      in_tvalid <= 1'b0;
      drain();
    end
    if (model.mismatches == 0 && model.pending.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int idle;
    forever begin
      idle = hold_req ? HOLD_CYCLES : pick_gap(out_calm);
      hold_req = 1'b0;
      if (idle > 0) begin
        out_tready <= 1'b0;
        repeat (idle) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      if (out_tvalid) model.compare_totals(totals_t'(out_tdata[OUT_FIELD_BITS-1:0]));
    end
  end

  initial begin
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
